// ===== rtl/core/mgm_pkg.sv =====
// shared types, constants, round function and mac doubling function for the magma cipher-modes block
// no dependencies
`default_nettype none

package mgm_pkg;

  localparam int ROUNDS   = 32;
  localparam int RND_W    = $clog2(ROUNDS);
  localparam int ROT_AMT  = 11;
  localparam int BLK_W    = 64;
  localparam int WORD_W   = 32;
  localparam int KIDX_W   = 3;
  localparam logic [BLK_W-1:0] MAC_POLY = 64'h0000_0000_0000_001b;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_C = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_D = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_IV    = 3'd6;

  // cipher mode codes
  localparam logic [2:0] MODE_ECB = 3'd0;
  localparam logic [2:0] MODE_CTR = 3'd1;
  localparam logic [2:0] MODE_OFB = 3'd2;
  localparam logic [2:0] MODE_CBC = 3'd3;
  localparam logic [2:0] MODE_CFB = 3'd4;
  localparam logic [2:0] MODE_MAC = 3'd5;

  typedef struct packed {
    logic start;
    logic inverse;
  } cipher_cmd_t;

  localparam logic [3:0] SBOX [8][16] = '{
    '{4'd12, 4'd4,  4'd6,  4'd2,  4'd10, 4'd5,  4'd11, 4'd9,
      4'd14, 4'd8,  4'd13, 4'd7,  4'd0,  4'd3,  4'd15, 4'd1},
    '{4'd6,  4'd8,  4'd2,  4'd3,  4'd9,  4'd10, 4'd5,  4'd12,
      4'd1,  4'd14, 4'd4,  4'd7,  4'd11, 4'd13, 4'd0,  4'd15},
    '{4'd11, 4'd3,  4'd5,  4'd8,  4'd2,  4'd15, 4'd10, 4'd13,
      4'd14, 4'd1,  4'd7,  4'd4,  4'd12, 4'd9,  4'd6,  4'd0},
    '{4'd12, 4'd8,  4'd2,  4'd1,  4'd13, 4'd4,  4'd15, 4'd6,
      4'd7,  4'd0,  4'd10, 4'd5,  4'd3,  4'd14, 4'd9,  4'd11},
    '{4'd7,  4'd15, 4'd5,  4'd10, 4'd8,  4'd1,  4'd6,  4'd13,
      4'd0,  4'd9,  4'd3,  4'd14, 4'd11, 4'd4,  4'd2,  4'd12},
    '{4'd5,  4'd13, 4'd15, 4'd6,  4'd9,  4'd2,  4'd12, 4'd10,
      4'd11, 4'd7,  4'd8,  4'd1,  4'd4,  4'd3,  4'd14, 4'd0},
    '{4'd8,  4'd14, 4'd2,  4'd5,  4'd6,  4'd9,  4'd1,  4'd12,
      4'd15, 4'd4,  4'd11, 4'd0,  4'd13, 4'd10, 4'd3,  4'd7},
    '{4'd1,  4'd7,  4'd14, 4'd13, 4'd0,  4'd5,  4'd8,  4'd3,
      4'd4,  4'd15, 4'd10, 4'd6,  4'd9,  4'd12, 4'd11, 4'd2}
  };

  // add key, substitute eight lanes, rotate left
  function automatic logic [WORD_W-1:0] f_round(input logic [WORD_W-1:0] k,
                                                input logic [WORD_W-1:0] a);
    logic [WORD_W-1:0] s;
    logic [WORD_W-1:0] t;
    s = k + a;
    t = '0;
    for (int i = 0; i < 8; i++) begin
      t[4*i +: 4] = SBOX[i][s[4*i +: 4]];
    end
    return (t << ROT_AMT) | (t >> (WORD_W - ROT_AMT));
  endfunction

  // doubling in GF(2^64) for the mac subkeys
  function automatic logic [BLK_W-1:0] f_dbl(input logic [BLK_W-1:0] v);
    logic [BLK_W-1:0] s;
    s = v << 1;
    return v[BLK_W-1] ? (s ^ MAC_POLY) : s;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/magma_block_cipher_modes.sv =====
// Magma 64-bit block cipher with ECB, CTR, OFB, CBC, CFB and MAC modes.
// Input channel: in_valid/in_stall carry one 64-bit block with msg_start,
// msg_end and end_padded flags. Output channel: out_valid/out_stall carry
// out_block and is_tag. Config port: cfg_we, cfg_index, cfg_data, written
// only while the block is idle, which the user must keep to and the block
// does not enforce; key words go into a small key ram. Chaining value,
// counter and mac subkey live in a three-entry state ram: each block reads
// them, runs the 32-round engine one round per cycle, then writes them back.
// A new block waits until the previous one is written back (in_stall is
// high outside idle); a beat with msg_start adds an extra encryption of
// zero that derives the mac subkey.
// In MAC mode only the last block of a message gives a beat (the tag, in
// the low 32 bits, with is_tag high); unused mode codes give no beat.
// Reset (rst_n low, synchronous) clears keys, mode, direction, init vector
// and state to zero. A stalled output holds its beat; a new block is still
// accepted while it waits, and its own result waits for the register.
// depends on mgm_pkg, mgm_ram, mgm_cipher
`default_nettype none

module magma_block_cipher_modes import mgm_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [BLK_W-1:0]     in_data_block,
  input  wire logic                 in_msg_start,
  input  wire logic                 in_msg_end,
  input  wire logic                 in_end_padded,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic      [BLK_W-1:0]     out_block,
  output logic                      out_is_tag,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BLK_W-1:0]     cfg_data
);

  localparam int KEY_DEPTH = 4;
  localparam int ST_DEPTH  = 3;
  localparam logic [1:0] ADDR_CHAIN = 2'd0;
  localparam logic [1:0] ADDR_CTR   = 2'd1;
  localparam logic [1:0] ADDR_SUB   = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_CHAIN, S_RD_CTR, S_RD_SUB, S_SUBKEY_WAIT,
    S_RUN, S_RUN_WAIT, S_FIN, S_WB_CHAIN, S_WB_CTR, S_WB_SUB
  } state_t;

  state_t st_r, st_nxt;

  logic [BLK_W-1:0] data_r;
  logic             start_r, last_r, pad_r;
  logic [BLK_W-1:0] chain_r, chain_nxt;
  logic [BLK_W-1:0] ctr_r, ctr_nxt;
  logic [BLK_W-1:0] sub_r, sub_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [BLK_W-1:0] out_block_r, out_block_nxt;
  logic             out_tag_r, out_tag_nxt;
  logic [2:0]       mode_r;
  logic             dir_r;
  logic [BLK_W-1:0] iv_r;
  logic [KEY_DEPTH-1:0] key_vld_r;
  logic [ST_DEPTH-1:0]  st_vld_r, st_vld_nxt;
  logic             key_sel_r, key_vq_r, st_vq_r;

  logic             accept;
  logic             key_we;
  logic [BLK_W-1:0] key_rdata;
  logic [WORD_W-1:0] key_word;
  logic [KIDX_W-1:0] key_idx;

  logic             st_we;
  logic [1:0]       st_waddr, st_raddr;
  logic [BLK_W-1:0] st_wdata, st_rdata, st_val;

  cipher_cmd_t      cmd;
  logic [BLK_W-1:0] eng_in, eng_out;
  logic             eng_done;
  logic [BLK_W-1:0] mac_k1, mac_kl;
  logic             out_free;

  assign accept     = in_valid && !in_stall;
  assign in_stall   = (st_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_block  = out_block_r;
  assign out_is_tag = out_tag_r;
  assign out_free   = !out_valid_r || !out_stall;

  // key ram: one 64-bit row per key register (KEY_A to KEY_D), odd key word in the low half
  assign key_we = cfg_we && ((cfg_index == CFG_KEY_A) || (cfg_index == CFG_KEY_B) ||
                             (cfg_index == CFG_KEY_C) || (cfg_index == CFG_KEY_D));

  mgm_ram #(.WIDTH(BLK_W), .DEPTH(KEY_DEPTH)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (cfg_index[1:0]),
    .wdata (cfg_data),
    .raddr (key_idx[KIDX_W-1:1]),
    .rdata (key_rdata)
  );

  // rows never written read as zero
  assign key_word = !key_vq_r ? '0 :
                    key_sel_r ? key_rdata[WORD_W-1:0] : key_rdata[BLK_W-1:WORD_W];

  mgm_ram #(.WIDTH(BLK_W), .DEPTH(ST_DEPTH)) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  assign st_val = st_vq_r ? st_rdata : '0;

  mgm_cipher u_cipher (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .blk_in  (eng_in),
    .key_in  (key_word),
    .key_idx (key_idx),
    .done    (eng_done),
    .blk_out (eng_out)
  );

  assign mac_k1 = f_dbl(sub_r);
  assign mac_kl = pad_r ? f_dbl(mac_k1) : mac_k1;

  always_comb begin
    st_nxt        = st_r;
    chain_nxt     = chain_r;
    ctr_nxt       = ctr_r;
    sub_nxt       = sub_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_block_nxt = out_block_r;
    out_tag_nxt   = out_tag_r;
    st_vld_nxt    = st_vld_r;
    st_we         = 1'b0;
    st_waddr      = ADDR_CHAIN;
    st_wdata      = chain_r;
    st_raddr      = ADDR_CHAIN;
    cmd           = '0;
    eng_in        = '0;

    unique case (st_r)
      S_IDLE: begin
        if (accept) begin
          st_nxt = S_RD_CHAIN;
        end
      end
      S_RD_CHAIN: begin
        chain_nxt = st_val;
        st_raddr  = ADDR_CTR;
        st_nxt    = S_RD_CTR;
      end
      S_RD_CTR: begin
        ctr_nxt  = st_val;
        st_raddr = ADDR_SUB;
        st_nxt   = S_RD_SUB;
      end
      S_RD_SUB: begin
        sub_nxt = st_val;
        if (start_r) begin
          // message start: reload chain and counter from the init vector (chain zero in MAC mode) and derive E(0)
          chain_nxt   = (mode_r == MODE_MAC) ? '0 : iv_r;
          ctr_nxt     = {iv_r[BLK_W-1:WORD_W], {WORD_W{1'b0}}};
          cmd.start   = 1'b1;
          cmd.inverse = 1'b0;
          eng_in      = '0;
          st_nxt      = S_SUBKEY_WAIT;
        end else begin
          st_nxt = S_RUN;
        end
      end
      S_SUBKEY_WAIT: begin
        if (eng_done) begin
          sub_nxt = eng_out;
          st_nxt  = S_RUN;
        end
      end
      S_RUN: begin
        cmd.start = 1'b1;
        st_nxt    = S_RUN_WAIT;
        case (mode_r) inside
          MODE_ECB: begin
            eng_in      = data_r;
            cmd.inverse = dir_r;
          end
          MODE_CTR: eng_in = ctr_r;
          MODE_OFB, MODE_CFB: eng_in = chain_r;
          MODE_CBC: begin
            eng_in      = dir_r ? data_r : (data_r ^ chain_r);
            cmd.inverse = dir_r;
          end
          MODE_MAC: begin
            eng_in = last_r ? (data_r ^ chain_r ^ mac_kl) : (data_r ^ chain_r);
          end
          default: begin
            // unused mode code: no result, state written back unchanged unless the block started a message
            cmd.start = 1'b0;
            st_nxt    = S_WB_CHAIN;
          end
        endcase
      end
      S_RUN_WAIT: begin
        if (eng_done) begin
          st_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if ((mode_r == MODE_MAC) && !last_r) begin
          chain_nxt = eng_out;
          st_nxt    = S_WB_CHAIN;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_tag_nxt   = 1'b0;
          st_nxt        = S_WB_CHAIN;
          case (mode_r)
            MODE_ECB: out_block_nxt = eng_out;
            MODE_CTR: begin
              out_block_nxt = data_r ^ eng_out;
              ctr_nxt       = ctr_r + BLK_W'(1);
            end
            MODE_OFB: begin
              out_block_nxt = data_r ^ eng_out;
              chain_nxt     = eng_out;
            end
            MODE_CBC: begin
              if (dir_r) begin
                out_block_nxt = eng_out ^ chain_r;
                chain_nxt     = data_r;
              end else begin
                out_block_nxt = eng_out;
                chain_nxt     = eng_out;
              end
            end
            MODE_CFB: begin
              out_block_nxt = data_r ^ eng_out;
              chain_nxt     = dir_r ? data_r : (data_r ^ eng_out);
            end
            default: begin
              // mac tag: high half of the final encryption
              out_block_nxt = {{WORD_W{1'b0}}, eng_out[BLK_W-1:WORD_W]};
              out_tag_nxt   = 1'b1;
              chain_nxt     = '0;
            end
          endcase
        end
      end
      S_WB_CHAIN: begin
        st_we      = 1'b1;
        st_waddr   = ADDR_CHAIN;
        st_wdata   = chain_r;
        st_vld_nxt = st_vld_r | ST_DEPTH'(1);
        st_nxt     = S_WB_CTR;
      end
      S_WB_CTR: begin
        st_we      = 1'b1;
        st_waddr   = ADDR_CTR;
        st_wdata   = ctr_r;
        st_vld_nxt = st_vld_r | ST_DEPTH'(2);
        st_nxt     = S_WB_SUB;
      end
      S_WB_SUB: begin
        st_we      = 1'b1;
        st_waddr   = ADDR_SUB;
        st_wdata   = sub_r;
        st_vld_nxt = st_vld_r | ST_DEPTH'(4);
        st_nxt     = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
      mode_r      <= MODE_ECB;
      dir_r       <= 1'b0;
      iv_r        <= '0;
      key_vld_r   <= '0;
      st_vld_r    <= '0;
      key_vq_r    <= 1'b0;
      st_vq_r     <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      st_vld_r    <= st_vld_nxt;
      key_vq_r    <= key_vld_r[key_idx[KIDX_W-1:1]];
      st_vq_r     <= st_vld_r[st_raddr];
      if (key_we) begin
        key_vld_r[cfg_index[1:0]] <= 1'b1;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MODE: mode_r <= cfg_data[2:0];
          CFG_DIR:  dir_r  <= cfg_data[0];
          CFG_IV:   iv_r   <= cfg_data;
          default: ;
        endcase
      end
    end
    key_sel_r   <= key_idx[0];
    chain_r     <= chain_nxt;
    ctr_r       <= ctr_nxt;
    sub_r       <= sub_nxt;
    out_block_r <= out_block_nxt;
    out_tag_r   <= out_tag_nxt;
    if (accept) begin
      data_r  <= in_data_block;
      start_r <= in_msg_start;
      last_r  <= in_msg_end;
      pad_r   <= in_end_padded;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mgm_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none

module mgm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/mgm_cipher.sv =====
// iterative magma feistel engine, one round per cycle
// depends on mgm_pkg; round keys come from the key ram in the cycle after key_idx
`default_nettype none

module mgm_cipher import mgm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cipher_cmd_t       cmd,
  input  wire logic [BLK_W-1:0]  blk_in,
  input  wire logic [WORD_W-1:0] key_in,
  output logic      [KIDX_W-1:0] key_idx,
  output logic                   done,
  output logic      [BLK_W-1:0]  blk_out
);

  logic              busy_r;
  logic              done_r;
  logic              inv_r;
  logic [RND_W-1:0]  rnd_r;
  logic [WORD_W-1:0] hi_r;
  logic [WORD_W-1:0] lo_r;
  logic [RND_W-1:0]  key_rnd;
  logic [RND_W-1:0]  eff_rnd;
  logic              key_inv;
  logic [WORD_W-1:0] n_word;

  // key for the next round is fetched while the current one is computed
  always_comb begin
    key_rnd = busy_r ? rnd_r + RND_W'(1) : '0;
    key_inv = busy_r ? inv_r : cmd.inverse;
    eff_rnd = key_inv ? RND_W'(ROUNDS - 1) - key_rnd : key_rnd;
    if (int'(eff_rnd) < ROUNDS - 8) begin
      key_idx = eff_rnd[KIDX_W-1:0];
    end else begin
      key_idx = ~eff_rnd[KIDX_W-1:0];
    end
  end

  assign n_word  = f_round(key_in, lo_r) ^ hi_r;
  assign done    = done_r;
  assign blk_out = {hi_r, lo_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        busy_r <= 1'b1;
        rnd_r  <= '0;
        inv_r  <= cmd.inverse;
        hi_r   <= blk_in[BLK_W-1:WORD_W];
        lo_r   <= blk_in[WORD_W-1:0];
      end else if (busy_r) begin
        if (rnd_r == RND_W'(ROUNDS - 1)) begin
          // last round leaves the halves unswapped
          hi_r   <= n_word;
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          hi_r  <= lo_r;
          lo_r  <= n_word;
          rnd_r <= rnd_r + RND_W'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire
